/* src/rfb_pkg.sv */
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, constants and color packing for the rotated framebuffer
// pixel writer.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int MAX_DIM_DEF     = 8192;
  localparam int MAX_BYTES_DEF   = 4;
  localparam int QUEUE_DEPTH     = 4;

  localparam int COORD_W         = 13;
  localparam int COLOR_W         = 32;
  localparam int ADDR_W          = 28;
  localparam int BYTE_W          = 8;
  localparam int SIZE_W          = 14;
  localparam int STRIDE_W        = 16;
  localparam int NB_W            = 3;
  localparam int BYTE_IDX_W      = 2;
  localparam int LAYOUT_W        = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_TDATA_W      = 64;
  localparam int OUT_TDATA_W     = 40;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION     = 3'd0,
    REG_PANEL_WIDTH  = 3'd1,
    REG_PANEL_HEIGHT = 3'd2,
    REG_LINE_STRIDE  = 3'd3,
    REG_BYTES_PER_PX = 3'd4,
    REG_RED_LAYOUT   = 3'd5,
    REG_GREEN_LAYOUT = 3'd6,
    REG_BLUE_LAYOUT  = 3'd7
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0]   RST_PANEL_WIDTH  = 14'd1080;
  localparam logic [SIZE_W-1:0]   RST_PANEL_HEIGHT = 14'd1920;
  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 16'd4320;
  localparam logic [NB_W-1:0]     RST_BYTES_PER_PX = 3'd4;
  localparam logic [LAYOUT_W-1:0] RST_RED_LAYOUT   = 10'd272;
  localparam logic [LAYOUT_W-1:0] RST_GREEN_LAYOUT = 10'd264;
  localparam logic [LAYOUT_W-1:0] RST_BLUE_LAYOUT  = 10'd256;

  typedef struct packed {
    rot_t                  rotation;
    logic [SIZE_W-1:0]     panel_width;
    logic [SIZE_W-1:0]     panel_height;
    logic [STRIDE_W-1:0]   line_stride;
    logic [NB_W-1:0]       bytes_per_pixel;
    logic [LAYOUT_W-1:0]   red_layout;
    logic [LAYOUT_W-1:0]   green_layout;
    logic [LAYOUT_W-1:0]   blue_layout;
  } cfg_t;

  // one pixel ready for byte writes
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] word;
    logic [NB_W-1:0]    nb;
  } pix_entry_t;

  function automatic logic [COLOR_W-1:0] scale_channel(input logic [7:0] c8,
                                                      input logic [LAYOUT_W-1:0] layout);
    logic [4:0]  off;
    logic [4:0]  len;
    logic [15:0] v;
    off = layout[4:0];
    len = layout[9:5];
    if (len == 5'd0) begin
      v = 16'd0;
    end else if (len >= 5'd16) begin
      v = {c8, 8'd0};
    end else if (len >= 5'd8) begin
      v = 16'(c8) << (len - 5'd8);
    end else begin
      v = 16'(c8 >> (5'd8 - len));
    end
    return COLOR_W'(v) << off;
  endfunction

endpackage

/* src/rfb_front.sv */
// ----------------------------------------------------------------------------
// rfb_front
// Maps logical coordinates onto the panel, drops pixels outside it, packs
// the color and computes the byte address in two pipeline stages.
// ----------------------------------------------------------------------------
module rfb_front #(
  parameter int MAX_DIM   = rfb_pkg::MAX_DIM_DEF,
  parameter int MAX_BYTES = rfb_pkg::MAX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rfb_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rfb_pkg::COORD_W-1:0]      in_column,
  input  logic [rfb_pkg::COORD_W-1:0]      in_row,
  input  logic [rfb_pkg::COLOR_W-1:0]      in_color,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rfb_pkg::pix_entry_t              out_entry
);

  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int PC_W      = $clog2(MAX_DIM);
  localparam int BASE_W    = (DIM_W > rfb_pkg::COORD_W) ? DIM_W : rfb_pkg::COORD_W;
  localparam int SW        = BASE_W + 2;
  localparam int ROW_OFF_W = PC_W + rfb_pkg::STRIDE_W;
  localparam int COL_OFF_W = PC_W + rfb_pkg::NB_W;

  logic [SW-1:0] max_dim;
  logic [SW-1:0] w_full;
  logic [SW-1:0] h_full;
  logic [SW-1:0] w;
  logic [SW-1:0] h;
  logic [SW-1:0] lx;
  logic [SW-1:0] ly;
  logic [SW-1:0] px;
  logic [SW-1:0] py;
  logic          on_panel;
  logic [rfb_pkg::NB_W-1:0]    nb_clamped;
  logic [rfb_pkg::COLOR_W-1:0] word;

  logic                        s1_valid;
  logic [PC_W-1:0]             s1_px;
  logic [PC_W-1:0]             s1_py;
  logic [rfb_pkg::COLOR_W-1:0] s1_word;
  logic [rfb_pkg::NB_W-1:0]    s1_nb;
  logic                        s1_adv;

  logic                        s2_valid;
  rfb_pkg::pix_entry_t         s2_entry;
  logic                        s2_adv;

  logic [ROW_OFF_W-1:0]        row_off;
  logic [COL_OFF_W-1:0]        col_off;

  always_comb begin
    max_dim = SW'(MAX_DIM);
    w_full  = SW'(cfg.panel_width);
    h_full  = SW'(cfg.panel_height);
    w       = (w_full > max_dim) ? max_dim : w_full;
    h       = (h_full > max_dim) ? max_dim : h_full;
    lx      = SW'(in_column);
    ly      = SW'(in_row);
    case (cfg.rotation)
      rfb_pkg::ROT_90: begin
        px = w - SW'(1) - ly;
        py = lx;
      end
      rfb_pkg::ROT_180: begin
        px = w - SW'(1) - lx;
        py = h - SW'(1) - ly;
      end
      rfb_pkg::ROT_270: begin
        px = ly;
        py = h - SW'(1) - lx;
      end
      default: begin
        px = lx;
        py = ly;
      end
    endcase
    // top bit is the sign of the wrapped difference
    on_panel = !px[SW-1] && (px < w) && !py[SW-1] && (py < h);

    if (cfg.bytes_per_pixel < rfb_pkg::NB_W'(2)) begin
      nb_clamped = rfb_pkg::NB_W'(2);
    end else if (cfg.bytes_per_pixel > rfb_pkg::NB_W'(MAX_BYTES)) begin
      nb_clamped = rfb_pkg::NB_W'(MAX_BYTES);
    end else begin
      nb_clamped = cfg.bytes_per_pixel;
    end

    word = rfb_pkg::scale_channel(in_color[23:16], cfg.red_layout)
         | rfb_pkg::scale_channel(in_color[15:8],  cfg.green_layout)
         | rfb_pkg::scale_channel(in_color[7:0],   cfg.blue_layout);
  end

  assign s2_adv    = !s2_valid || out_ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign in_ready  = s1_adv;
  assign out_valid = s2_valid;
  assign out_entry = s2_entry;

  assign row_off = ROW_OFF_W'(s1_py) * ROW_OFF_W'(cfg.line_stride);
  assign col_off = COL_OFF_W'(s1_px) * COL_OFF_W'(s1_nb);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= in_valid && on_panel;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_px   <= px[PC_W-1:0];
      s1_py   <= py[PC_W-1:0];
      s1_word <= word;
      s1_nb   <= nb_clamped;
    end
    if (s2_adv) begin
      // address wraps at the width of the address field
      s2_entry.addr <= rfb_pkg::ADDR_W'(row_off) + rfb_pkg::ADDR_W'(col_off);
      s2_entry.word <= s1_word;
      s2_entry.nb   <= s1_nb;
    end
  end

endmodule

/* src/rfb_queue.sv */
// ----------------------------------------------------------------------------
// rfb_queue
// Small first-in first-out queue of packed pixels between front and back.
// ----------------------------------------------------------------------------
module rfb_queue #(
  parameter int DEPTH = rfb_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rfb_pkg::pix_entry_t in_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output rfb_pkg::pix_entry_t out_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfb_pkg::pix_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != CNT_W'(0));
  assign out_entry = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

endmodule

/* src/rfb_back.sv */
// ----------------------------------------------------------------------------
// rfb_back
// Splits each packed pixel into byte writes, one per cycle while the output is
// not stalled, through an output register.
// ----------------------------------------------------------------------------
module rfb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rfb_pkg::pix_entry_t           in_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfb_pkg::ADDR_W-1:0]    out_address,
  output logic [rfb_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last
);

  logic                             cur_valid;
  rfb_pkg::pix_entry_t              cur;
  logic [rfb_pkg::BYTE_IDX_W-1:0]   k;
  logic                             is_last;
  logic                             out_free;
  logic                             emit;
  logic [rfb_pkg::COLOR_W-1:0]      shifted;

  assign is_last  = (rfb_pkg::NB_W'(k) + rfb_pkg::NB_W'(1)) == cur.nb;
  assign out_free = !out_valid || out_ready;
  assign emit     = cur_valid && out_free;
  // next pixel loads while its predecessor's last byte goes out
  assign in_ready = !cur_valid || (emit && is_last);
  assign shifted  = cur.word >> {k, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        cur_valid <= in_valid;
        k         <= '0;
      end else if (emit) begin
        k <= k + rfb_pkg::BYTE_IDX_W'(1);
      end
      if (out_free) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cur <= in_entry;
    end
    if (emit) begin
      out_address <= cur.addr + rfb_pkg::ADDR_W'(k);
      out_byte    <= shifted[rfb_pkg::BYTE_W-1:0];
      out_last    <= is_last;
    end
  end

endmodule

/* src/rotated_framebuffer_pixel_writer_top.sv */
// ----------------------------------------------------------------------------
// rotated_framebuffer_pixel_writer_top
// Rotated framebuffer pixel writer: maps a logical pixel onto the panel,
// packs its color and emits it as little-endian byte writes.
// ----------------------------------------------------------------------------
// path: front stages s1 and s2, queue, back pixel and output registers
// throughput: one byte write per cycle while m_tready is high, bytes_per_pixel
// (2 to 4) writes per pixel, with the next pixel loaded as the last byte goes
// out; pixels outside the panel are accepted and give nothing
// reset: synchronous rst empties the pipeline and queue and restores all
// configuration registers to their defaults; no clearing pass
module rotated_framebuffer_pixel_writer_top #(
  parameter int MAX_DIM   = rfb_pkg::MAX_DIM_DEF,
  parameter int MAX_BYTES = rfb_pkg::MAX_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // column [12:0], row [25:13], pixel_color [57:26], zero [63:58]
  input  logic [rfb_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // write_address [27:0], write_byte [35:28], zero [39:36]
  output logic [rfb_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);

  rfb_pkg::cfg_t       cfg;
  logic                f_valid;
  logic                f_ready;
  rfb_pkg::pix_entry_t f_entry;
  logic                q_valid;
  logic                q_ready;
  rfb_pkg::pix_entry_t q_entry;
  logic [rfb_pkg::ADDR_W-1:0] wr_address;
  logic [rfb_pkg::BYTE_W-1:0] wr_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation        <= rfb_pkg::ROT_0;
      cfg.panel_width     <= rfb_pkg::RST_PANEL_WIDTH;
      cfg.panel_height    <= rfb_pkg::RST_PANEL_HEIGHT;
      cfg.line_stride     <= rfb_pkg::RST_LINE_STRIDE;
      cfg.bytes_per_pixel <= rfb_pkg::RST_BYTES_PER_PX;
      cfg.red_layout      <= rfb_pkg::RST_RED_LAYOUT;
      cfg.green_layout    <= rfb_pkg::RST_GREEN_LAYOUT;
      cfg.blue_layout     <= rfb_pkg::RST_BLUE_LAYOUT;
    end else if (cfg_we) begin
      case (rfb_pkg::cfg_reg_t'(cfg_index))
        rfb_pkg::REG_ROTATION:     cfg.rotation        <= rfb_pkg::rot_t'(cfg_data[1:0]);
        rfb_pkg::REG_PANEL_WIDTH:  cfg.panel_width     <= cfg_data[rfb_pkg::SIZE_W-1:0];
        rfb_pkg::REG_PANEL_HEIGHT: cfg.panel_height    <= cfg_data[rfb_pkg::SIZE_W-1:0];
        rfb_pkg::REG_LINE_STRIDE:  cfg.line_stride     <= cfg_data[rfb_pkg::STRIDE_W-1:0];
        rfb_pkg::REG_BYTES_PER_PX: cfg.bytes_per_pixel <= cfg_data[rfb_pkg::NB_W-1:0];
        rfb_pkg::REG_RED_LAYOUT:   cfg.red_layout      <= cfg_data[rfb_pkg::LAYOUT_W-1:0];
        rfb_pkg::REG_GREEN_LAYOUT: cfg.green_layout    <= cfg_data[rfb_pkg::LAYOUT_W-1:0];
        rfb_pkg::REG_BLUE_LAYOUT:  cfg.blue_layout     <= cfg_data[rfb_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  rfb_front #(
    .MAX_DIM   (MAX_DIM),
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_column (s_tdata[12:0]),
    .in_row    (s_tdata[25:13]),
    .in_color  (s_tdata[57:26]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_entry (f_entry)
  );

  rfb_queue #(
    .DEPTH (rfb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_entry  (f_entry),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_entry (q_entry)
  );

  rfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_entry    (q_entry),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_address (wr_address),
    .out_byte    (wr_byte),
    .out_last    (m_tlast)
  );

  assign m_tdata = {4'b0000, wr_byte, wr_address};

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotated framebuffer pixel writer. Pixels are
// streamed in under a series of register setups (rotations, clamped and
// empty panels, odd byte counts, unusual channel layouts). A scoreboard
// predicts every byte write and compares it with what the block emits, while
// both stream sides stall at random, except in the quiet final phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfb_pkg::*;

  localparam int HALF_PERIOD      = 4;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 12;
  localparam int RANDOM_PHASES    = 12;
  localparam int PIXELS_PER_PHASE = 24;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_write_t;

  class byte_write_scoreboard;
    rot_t                rotation;
    logic [SIZE_W-1:0]   panel_width;
    logic [SIZE_W-1:0]   panel_height;
    logic [STRIDE_W-1:0] line_stride;
    logic [NB_W-1:0]     bytes_per_pixel;
    logic [LAYOUT_W-1:0] red_layout;
    logic [LAYOUT_W-1:0] green_layout;
    logic [LAYOUT_W-1:0] blue_layout;
    byte_write_t         expected_writes[$];
    int                  errors;

    function new();
      rotation        = ROT_0;
      panel_width     = RST_PANEL_WIDTH;
      panel_height    = RST_PANEL_HEIGHT;
      line_stride     = RST_LINE_STRIDE;
      bytes_per_pixel = RST_BYTES_PER_PX;
      red_layout      = RST_RED_LAYOUT;
      green_layout    = RST_GREEN_LAYOUT;
      blue_layout     = RST_BLUE_LAYOUT;
      errors          = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ROTATION:     rotation        = rot_t'(value[1:0]);
        REG_PANEL_WIDTH:  panel_width     = value[SIZE_W-1:0];
        REG_PANEL_HEIGHT: panel_height    = value[SIZE_W-1:0];
        REG_LINE_STRIDE:  line_stride     = value[STRIDE_W-1:0];
        REG_BYTES_PER_PX: bytes_per_pixel = value[NB_W-1:0];
        REG_RED_LAYOUT:   red_layout      = value[LAYOUT_W-1:0];
        REG_GREEN_LAYOUT: green_layout    = value[LAYOUT_W-1:0];
        REG_BLUE_LAYOUT:  blue_layout     = value[LAYOUT_W-1:0];
        default: ;
      endcase
    endfunction

    // widen or narrow an 8-bit channel to its length, then move it to its offset
    function logic [COLOR_W-1:0] place_channel(logic [7:0] c8, logic [LAYOUT_W-1:0] layout);
      int          len;
      logic [63:0] bits;
      len = int'(layout[9:5]);
      if (len == 0) return '0;
      if (len > 16) len = 16;
      if (len >= 8) bits = 64'(c8) << (len - 8);
      else bits = 64'(c8) >> (8 - len);
      bits = bits << layout[4:0];
      return bits[COLOR_W-1:0];
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             logic [COLOR_W-1:0] argb);
      longint             lx, ly, w, h, px, py, nb;
      logic [COLOR_W-1:0] word;
      logic [ADDR_W-1:0]  base;
      byte_write_t        wr;
      lx = col;
      ly = row;
      w  = panel_width;
      h  = panel_height;
      nb = bytes_per_pixel;
      if (w > MAX_DIM_DEF) w = MAX_DIM_DEF;
      if (h > MAX_DIM_DEF) h = MAX_DIM_DEF;
      if (nb < 2) nb = 2;
      if (nb > MAX_BYTES_DEF) nb = MAX_BYTES_DEF;
      case (rotation)
        ROT_90:  begin px = w - 1 - ly; py = lx;         end
        ROT_180: begin px = w - 1 - lx; py = h - 1 - ly; end
        ROT_270: begin px = ly;         py = h - 1 - lx; end
        default: begin px = lx;         py = ly;         end
      endcase
      if (px < 0 || px >= w || py < 0 || py >= h) return;
      word = place_channel(argb[23:16], red_layout) |
             place_channel(argb[15:8], green_layout) |
             place_channel(argb[7:0], blue_layout);
      base = ADDR_W'(py * longint'(line_stride) + px * nb);
      for (int k = 0; k < nb; k++) begin
        wr.addr = base + ADDR_W'(k);
        wr.data = word[8*k +: 8];
        wr.last = (k == nb - 1);
        expected_writes.push_back(wr);
      end
    endfunction

    function void check_byte_write(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                                   logic last);
      byte_write_t want;
      if (expected_writes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected byte write: addr %h byte %h last %b", addr, data, last);
        return;
      end
      want = expected_writes.pop_front();
      if (addr !== want.addr || data !== want.data || last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("byte write mismatch: expected addr %h byte %h last %b, got %h %h %b",
                   want.addr, want.data, want.last, addr, data, last);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  m_tlast;
  bit                    quiet     = 1'b0;
  int unsigned           cycles    = 0;

  byte_write_scoreboard sb = new();

  rotated_framebuffer_pixel_writer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_byte_write(m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: BYTE_W], m_tlast);
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 24)) @(posedge clk);
    end
  end

  function automatic int chan_layout(int len, int off);
    return (len << 5) | off;
  endfunction

  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.set_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic write_setup(rot_t rot, int width, int height, int stride, int nbytes,
                             int red, int green, int blue);
    write_reg(REG_ROTATION, int'(rot));
    write_reg(REG_PANEL_WIDTH, width);
    write_reg(REG_PANEL_HEIGHT, height);
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_BYTES_PER_PX, nbytes);
    write_reg(REG_RED_LAYOUT, red);
    write_reg(REG_GREEN_LAYOUT, green);
    write_reg(REG_BLUE_LAYOUT, blue);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(int col, int row, logic [COLOR_W-1:0] argb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({argb, COORD_W'(row), COORD_W'(col)});
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(COORD_W'(col), COORD_W'(row), argb);
  endtask

  // hold the input until every pending byte write is out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int   w, h, stride, nbytes, lim_col, lim_row;
    int   red, green, blue;
    rot_t rot;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset setup: 1080x1920 ARGB8888, no rotation
    send_pixel(0, 0, 32'h0000_0000);
    send_pixel(1079, 1919, 32'hFFFF_FFFF);
    send_pixel(1080, 0, 32'h00FF_0000);
    send_pixel(0, 1920, 32'h0000_FF00);
    send_pixel(8191, 8191, 32'hFFFF_FFFF);
    send_pixel(5, 7, 32'h1234_5678);
    send_pixel(1079, 0, 32'hAA55_AA55);
    send_pixel(0, 1919, 32'h55AA_55AA);
    wait_idle();

    // oversized panel, widest stride so the address wraps, bits pushed past the word
    write_setup(ROT_90, 16383, 8192, 65535, 7, chan_layout(31, 31), chan_layout(16, 16),
                chan_layout(1, 0));
    send_pixel(8191, 8191, 32'hFFFF_FFFF);
    send_pixel(0, 0, 32'h00C3_A5F0);
    send_pixel(4000, 123, 32'h0180_7F01);
    wait_idle();

    // single pixel panel, 565 layout, byte count below range
    write_setup(ROT_180, 1, 1, 2, 1, chan_layout(5, 11), chan_layout(6, 5),
                chan_layout(5, 0));
    send_pixel(0, 0, 32'h00F8_FC1F);
    send_pixel(1, 0, 32'hFFFF_FFFF);
    send_pixel(0, 1, 32'hFFFF_FFFF);
    wait_idle();

    // zero width: nothing lands on the panel
    write_setup(ROT_270, 0, 5, 0, 0, chan_layout(10, 3), chan_layout(8, 8),
                chan_layout(8, 0));
    send_pixel(0, 0, 32'hFFFF_FFFF);
    send_pixel(3, 2, 32'h0012_3456);
    wait_idle();

    // three bytes, red in the low byte, green dropped
    write_setup(ROT_270, 7, 5, 40, 3, chan_layout(8, 0), chan_layout(0, 8),
                chan_layout(8, 16));
    send_pixel(0, 0, 32'h0011_2233);
    send_pixel(4, 6, 32'hFFEE_DDCC);
    send_pixel(5, 0, 32'hFFFF_FFFF);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase >= RANDOM_PHASES - 2) quiet = 1'b1;
      rot = rot_t'($urandom_range(0, 3));
      case (phase % 4)
        0: begin w = $urandom_range(1, 8192); h = $urandom_range(1, 8192); end
        1: begin w = $urandom_range(8192, 16383); h = $urandom_range(4096, 16383); end
        default: begin w = $urandom_range(1, 48); h = $urandom_range(1, 48); end
      endcase
      nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
      stride = $urandom_range(0, 1) ? $urandom_range(0, 65535) : (w * 4) % 65536;
      red    = $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                    : chan_layout($urandom_range(4, 8), $urandom_range(0, 24));
      green  = $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                    : chan_layout($urandom_range(4, 8), $urandom_range(0, 24));
      blue   = $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                    : chan_layout($urandom_range(4, 8), $urandom_range(0, 24));
      write_setup(rot, w, h, stride, nbytes, red, green, blue);

      // logical bounds after clamping; 90 and 270 swap the axes
      if (w > MAX_DIM_DEF) w = MAX_DIM_DEF;
      if (h > MAX_DIM_DEF) h = MAX_DIM_DEF;
      if (rot == ROT_90 || rot == ROT_270) begin
        lim_col = h;
        lim_row = w;
      end else begin
        lim_col = w;
        lim_row = h;
      end

      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        if ($urandom_range(0, 6) == 0)
          send_pixel($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom);
        else
          send_pixel($urandom_range(0, lim_col - 1), $urandom_range(0, lim_row - 1),
                     $urandom);
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/rfb_pkg.sv
src/rfb_front.sv
src/rfb_queue.sv
src/rfb_back.sv
src/rotated_framebuffer_pixel_writer_top.sv
sim/tb_top.sv
